[src/pl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pl_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_DELETE   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_TRAVERSE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  localparam int unsigned PosW  = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned FposW = 6;

  typedef struct packed {
    mode_e                    mode;
    logic [PosW-1:0]          position;
    logic signed [DataW-1:0]  value;
  } cmd_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  data_value;
    logic [FposW-1:0]         found_position;
    logic                     last_item;
  } result_t;

endpackage

`default_nettype wire

[src/pl_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module pl_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/positional_list_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// one command at a time; busy stays high until its last result is out
// error statuses and full/empty answers: result strobe in the cycle after start
// insert moves entries up a slot from the end, then writes; delete moves them down
// search: read, then compare each entry; traverse: read, then output each entry
// walks are paced by the single list memory, one registered read per step
// reset clears the entry count and control; results are never stalled
module positional_list_engine_core #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire pl_pkg::cmd_t    cmd_i,
  output logic                 busy,
  output logic                 result_valid_o,
  output pl_pkg::result_t      result_o
);

  import pl_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_MOVE,
    S_DEL_SHIFT,
    S_DEL_MOVE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_TRAV_RD,
    S_TRAV_OUT
  } state_e;

  state_e                  state_q;
  logic [CntW-1:0]         count_q;
  logic [CntW-1:0]         idx_q;
  logic [CntW-1:0]         pos_q;
  logic signed [DataW-1:0] val_q;
  logic                    res_valid_q;
  result_t                 res_q;

  logic                    step_dec;
  logic [CntW-1:0]         idx_step;
  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic [DataW-1:0]        mem_wdata;
  logic [IdxW-1:0]         mem_raddr;
  logic [DataW-1:0]        mem_rdata;
  logic                    accept;
  logic                    is_last;

  assign accept = start && (state_q == S_IDLE);

  // shared index unit: one incrementer/decrementer for every walk
  assign step_dec = (state_q == S_INS_SHIFT) || (state_q == S_INS_MOVE);
  assign idx_step = step_dec ? (idx_q - CntW'(1)) : (idx_q + CntW'(1));
  assign is_last  = (idx_step == count_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[IdxW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx_q[IdxW-1:0];
    case (state_q)
      S_INS_SHIFT: begin
        mem_raddr = idx_step[IdxW-1:0];
        if (idx_q == pos_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[IdxW-1:0];
          mem_wdata = val_q;
        end
      end
      S_INS_MOVE: begin
        mem_we = 1'b1;
      end
      S_DEL_SHIFT: begin
        mem_raddr = idx_step[IdxW-1:0];
      end
      S_DEL_MOVE: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  pl_mem #(
    .Depth(CAPACITY),
    .Width(DataW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      res_q       <= '{status: ST_OK, data_value: '0, found_position: '0, last_item: 1'b1};
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            pos_q <= CntW'(cmd_i.position);
            val_q <= cmd_i.value;
            case (cmd_i.mode)
              MODE_INSERT: begin
                if (count_q == CntW'(CAPACITY)) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= ST_FULL;
                end else if (cmd_i.position > PosW'(count_q)) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= ST_INVALID;
                end else begin
                  idx_q   <= count_q;
                  state_q <= S_INS_SHIFT;
                end
              end
              MODE_DELETE: begin
                if (count_q == '0) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= ST_EMPTY;
                end else if (cmd_i.position >= PosW'(count_q)) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= ST_INVALID;
                end else begin
                  idx_q   <= CntW'(cmd_i.position);
                  state_q <= S_DEL_SHIFT;
                end
              end
              MODE_SEARCH: begin
                if (count_q == '0) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= ST_EMPTY;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_SRCH_RD;
                end
              end
              MODE_TRAVERSE: begin
                if (count_q == '0) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= ST_EMPTY;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_TRAV_RD;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_INS_SHIFT: begin
          if (idx_q == pos_q) begin
            // new value lands at its slot this cycle
            count_q     <= count_q + CntW'(1);
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_INS_MOVE;
          end
        end
        S_INS_MOVE: begin
          idx_q   <= idx_step;
          state_q <= S_INS_SHIFT;
        end
        S_DEL_SHIFT: begin
          if (is_last) begin
            count_q     <= count_q - CntW'(1);
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_DEL_MOVE;
          end
        end
        S_DEL_MOVE: begin
          idx_q   <= idx_step;
          state_q <= S_DEL_SHIFT;
        end
        S_SRCH_RD: begin
          state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (mem_rdata == val_q) begin
            res_valid_q          <= 1'b1;
            res_q.found_position <= FposW'(idx_q);
            state_q              <= S_IDLE;
          end else if (is_last) begin
            res_valid_q  <= 1'b1;
            res_q.status <= ST_NOTFOUND;
            state_q      <= S_IDLE;
          end else begin
            idx_q   <= idx_step;
            state_q <= S_SRCH_RD;
          end
        end
        S_TRAV_RD: begin
          state_q <= S_TRAV_OUT;
        end
        S_TRAV_OUT: begin
          res_valid_q      <= 1'b1;
          res_q.data_value <= mem_rdata;
          res_q.last_item  <= is_last;
          if (is_last) begin
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_step;
            state_q <= S_TRAV_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // final result of a transaction coincides with the return to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_item |-> !busy)
    else $error("last result while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_item |-> busy)
    else $error("intermediate result after command finished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // an accepted command either starts a walk or answers at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || result_valid_o)
    else $error("command dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> result_valid_o && result_o.status == ST_OK)
    else $error("entry count changed without an ok result");

endmodule

`default_nettype wire

[tb/sv/plist_checker.sv]
`timescale 1ns / 1ps

module plist_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            busy_i,
  input  wire pl_pkg::cmd_t    cmd_i,
  input  wire logic            result_valid_i,
  input  wire pl_pkg::result_t result_i,
  output int                   error_count_o,
  output int                   pending_o,
  output int                   checked_o
);
  import pl_pkg::*;

  logic signed [DataW-1:0] shadow_list [CAPACITY];
  int unsigned             shadow_count;
  result_t                 pending_results [$];
  result_t                 want;

  function automatic result_t mk_result(status_e st, logic signed [DataW-1:0] data,
                                        logic [FposW-1:0] fpos, logic last);
    result_t r;
    r.status         = st;
    r.data_value     = data;
    r.found_position = fpos;
    r.last_item      = last;
    return r;
  endfunction

  // updates the shadow list and queues the results one command gives
  task automatic apply_list_cmd(input cmd_t c);
    int unsigned idx;
    bit          hit;
    hit = 1'b0;
    case (c.mode)
      MODE_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          pending_results.push_back(mk_result(ST_FULL, '0, '0, 1'b1));
        end else if (c.position > shadow_count) begin
          pending_results.push_back(mk_result(ST_INVALID, '0, '0, 1'b1));
        end else begin
          for (idx = shadow_count; idx > c.position; idx--) begin
            shadow_list[idx] = shadow_list[idx-1];
          end
          shadow_list[c.position] = c.value;
          shadow_count++;
          pending_results.push_back(mk_result(ST_OK, '0, '0, 1'b1));
        end
      end
      MODE_DELETE: begin
        if (shadow_count == 0) begin
          pending_results.push_back(mk_result(ST_EMPTY, '0, '0, 1'b1));
        end else if (c.position >= shadow_count) begin
          pending_results.push_back(mk_result(ST_INVALID, '0, '0, 1'b1));
        end else begin
          for (idx = c.position; idx + 1 < shadow_count; idx++) begin
            shadow_list[idx] = shadow_list[idx+1];
          end
          shadow_count--;
          pending_results.push_back(mk_result(ST_OK, '0, '0, 1'b1));
        end
      end
      MODE_SEARCH: begin
        if (shadow_count == 0) begin
          pending_results.push_back(mk_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          // first match wins
          for (idx = 0; idx < shadow_count; idx++) begin
            if (!hit && shadow_list[idx] == c.value) begin
              hit = 1'b1;
              pending_results.push_back(mk_result(ST_OK, '0, idx[FposW-1:0], 1'b1));
            end
          end
          if (!hit) pending_results.push_back(mk_result(ST_NOTFOUND, '0, '0, 1'b1));
        end
      end
      default: begin
        if (shadow_count == 0) begin
          pending_results.push_back(mk_result(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          for (idx = 0; idx < shadow_count; idx++) begin
            pending_results.push_back(mk_result(ST_OK, shadow_list[idx], '0,
                                                idx + 1 == shadow_count));
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      pending_results.delete();
      error_count_o = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      if (start_i && !busy_i) apply_list_cmd(cmd_i);
      if (result_valid_i) begin
        checked_o++;
        if (pending_results.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected result status=%0d data=%0d fpos=%0d last=%0b", $time,
                   result_i.status, result_i.data_value, result_i.found_position,
                   result_i.last_item);
        end else begin
          want = pending_results.pop_front();
          if (result_i !== want) begin
            error_count_o++;
            $display("%0t: mismatch expected status=%0d data=%0d fpos=%0d last=%0b", $time,
                     want.status, want.data_value, want.found_position, want.last_item);
            $display("%0t:          actual   status=%0d data=%0d fpos=%0d last=%0b", $time,
                     result_i.status, result_i.data_value, result_i.found_position,
                     result_i.last_item);
          end
        end
      end
      pending_o = pending_results.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import pl_pkg::*;

  localparam int unsigned CAPACITY  = 32;
  localparam int          NumRandom = 405;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  cmd_t    cmd_i  = '0;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  int error_count;
  int pending;
  int checked;
  int occupancy;
  int mode_tally [4];
  logic signed [DataW-1:0] value_pool [8];

  always #5 clk_i = ~clk_i;

  positional_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .cmd_i         (cmd_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  plist_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .cmd_i         (cmd_i),
    .result_valid_i(result_valid_o),
    .result_i      (result_o),
    .error_count_o (error_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic cmd_t mk_cmd(mode_e m, logic [PosW-1:0] p, logic signed [DataW-1:0] v);
    cmd_t c;
    c.mode     = m;
    c.position = p;
    c.value    = v;
    return c;
  endfunction

  // values from a small pool that can repeat so searches hit, plus extremes and noise
  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh8000_0000;
    if (r == 1) return 32'sh7fff_ffff;
    if (r < 6) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // one transaction: idle for gap cycles, then hold start until accepted
  task automatic issue(input cmd_t c, input int gap);
    logic [63:0] noise;
    repeat (gap) begin
      @(negedge clk_i);
      noise = {$urandom, $urandom};
      start <= 1'b0;
      cmd_i <= noise[$bits(cmd_t)-1:0];
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    mode_tally[c.mode]++;
    case (c.mode)
      MODE_INSERT: if (occupancy < CAPACITY && c.position <= occupancy) occupancy++;
      MODE_DELETE: if (occupancy > 0 && c.position < occupancy) occupancy--;
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int    n;
    int    target;
    int    roll;
    int    ins_cut;
    bit    bursty;
    cmd_t  c;

    occupancy = 0;
    bursty = 1'b1;
    target = CAPACITY;
    foreach (mode_tally[k]) mode_tally[k] = 0;
    foreach (value_pool[k]) value_pool[k] = $urandom;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty list answers, bad insert and delete positions, extremes, duplicates
    issue(mk_cmd(MODE_TRAVERSE, 8'd0, 32'sd0), 0);
    issue(mk_cmd(MODE_DELETE, 8'd0, 32'sd0), $urandom_range(0, 17));
    issue(mk_cmd(MODE_SEARCH, 8'd0, 32'sd0), 0);
    issue(mk_cmd(MODE_INSERT, 8'd1, 32'sd5), 0);
    issue(mk_cmd(MODE_INSERT, 8'd255, 32'sd5), $urandom_range(0, 17));
    issue(mk_cmd(MODE_INSERT, 8'd0, 32'sh8000_0000), 0);
    issue(mk_cmd(MODE_INSERT, 8'd1, 32'sh7fff_ffff), 0);
    issue(mk_cmd(MODE_INSERT, 8'd0, 32'sd0), $urandom_range(0, 17));
    issue(mk_cmd(MODE_INSERT, 8'd3, -32'sd1), 0);
    issue(mk_cmd(MODE_INSERT, 8'd2, 32'sh7fff_ffff), 0);
    issue(mk_cmd(MODE_SEARCH, 8'd0, 32'sh7fff_ffff), 0);
    issue(mk_cmd(MODE_SEARCH, 8'd0, -32'sd1), $urandom_range(0, 17));
    issue(mk_cmd(MODE_SEARCH, 8'd0, 32'sd0), 0);
    issue(mk_cmd(MODE_SEARCH, 8'd0, 32'sd5), 0);
    issue(mk_cmd(MODE_DELETE, 8'd5, 32'sd0), 0);
    issue(mk_cmd(MODE_DELETE, 8'd255, 32'sd0), $urandom_range(0, 17));
    issue(mk_cmd(MODE_TRAVERSE, 8'd0, 32'sd0), 0);
    issue(mk_cmd(MODE_DELETE, 8'd4, 32'sd0), 0);
    issue(mk_cmd(MODE_DELETE, 8'd0, 32'sd0), 0);
    issue(mk_cmd(MODE_TRAVERSE, 8'd0, 32'sd0), $urandom_range(0, 17));
    issue(mk_cmd(MODE_DELETE, 8'd0, 32'sd0), 0);
    issue(mk_cmd(MODE_DELETE, 8'd1, 32'sd0), 0);
    issue(mk_cmd(MODE_DELETE, 8'd0, 32'sd0), 0);
    issue(mk_cmd(MODE_TRAVERSE, 8'd0, 32'sd0), 0);
    drain();

    // random walk of the fill level toward a target that moves every phase
    for (n = 0; n < NumRandom; n++) begin
      if (n % 50 == 0 && n != 0) begin
        case ($urandom_range(0, 3))
          0: target = $urandom_range(0, 2);
          1: target = $urandom_range(CAPACITY - 2, CAPACITY);
          default: target = $urandom_range(0, CAPACITY);
        endcase
      end
      if (n % 40 == 0) bursty = $urandom_range(0, 2) != 0;
      if (n == NumRandom / 2) drain();

      ins_cut = (occupancy < target) ? 88 : (occupancy > target) ? 45 : 66;
      roll = $urandom_range(0, 99);
      if (roll < 12) c.mode = MODE_TRAVERSE;
      else if (roll < 32) c.mode = MODE_SEARCH;
      else if (roll < ins_cut) c.mode = MODE_INSERT;
      else c.mode = MODE_DELETE;

      c.position = PosW'($urandom_range(0, 255));
      if ($urandom_range(0, 9) != 0) begin
        if (c.mode == MODE_INSERT) c.position = PosW'($urandom_range(0, occupancy));
        else if (c.mode == MODE_DELETE && occupancy > 0)
          c.position = PosW'($urandom_range(0, occupancy - 1));
      end
      c.value = (c.mode == MODE_INSERT || c.mode == MODE_SEARCH) ? pick_value() : $urandom;

      issue(c, bursty ? $urandom_range(0, 17) : 0);
    end

    drain();
    repeat (80) @(negedge clk_i);

    $display("covered %0d inserts, %0d deletes, %0d searches, %0d traversals",
             mode_tally[MODE_INSERT], mode_tally[MODE_DELETE],
             mode_tally[MODE_SEARCH], mode_tally[MODE_TRAVERSE]);
    $display("%0d results compared, %0d mismatches", checked, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/pl_pkg.sv
src/pl_mem.sv
src/positional_list_engine_core.sv
tb/sv/plist_checker.sv
tb/sv/testbench.sv
